// ===== hw/rtl/mpbm_pkg.sv =====
// shared types, constants and helpers of the multi-pattern byte matcher
`default_nettype none
package mpbm_pkg;

  localparam int NODES    = 4096;
  localparam int NODE_W   = 12;
  localparam int CNT_W    = NODE_W + 1;
  localparam int HT_W     = NODE_W + 1;
  localparam int KEY_W    = NODE_W + 8;
  localparam int OFF_W    = 48;
  localparam int ID_W     = 16;

  localparam logic [6:0] MAX_DEPTH  = 7'd64;
  localparam logic [6:0] DISCARD_LEN = 7'd65;

  localparam logic [1:0] CMD_PAT   = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_TEXT  = 2'd2;
  localparam logic [1:0] CMD_START = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_PHASE = 2'd2;
  localparam logic [1:0] ST_CAP   = 2'd3;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       data_byte;
    logic             last_of_pattern;
    logic [ID_W-1:0]  pattern_id;
    logic [OFF_W-1:0] start_offset;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  match_id;
    logic [OFF_W-1:0] match_offset;
    logic             last_result;
  } out_word_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       chr;
    logic             last;
    logic [ID_W-1:0]  id;
    logic [OFF_W-1:0] offset;
  } op_t;

  typedef struct packed {
    logic              v;
    logic [NODE_W-1:0] node;
  } lnk_t;

  typedef struct packed {
    logic            v;
    logic [ID_W-1:0] id;
  } nout_t;

  typedef struct packed {
    logic              v;
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] child;
  } ht_ent_t;

  function automatic logic [HT_W-1:0] edge_hash(input logic [NODE_W-1:0] node,
                                                input logic [7:0] chr);
    return {1'b0, node} ^ {chr, {(HT_W-8){1'b0}}};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mpbm_front.sv =====
// front end: config register, case folding and intake of command words
`default_nettype none
module mpbm_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mpbm_pkg::in_word_t in_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data,
  input  wire logic              busy,
  input  wire logic              q_full,
  output logic                   q_push,
  output mpbm_pkg::op_t          q_word
);
  import mpbm_pkg::*;

  logic nocase_r;
  logic is_upper;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nocase_r <= 1'b0;
    end else if (cfg_valid) begin
      nocase_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full && !busy;
  assign q_push    = in_valid && in_ready;
  assign is_upper  = (in_data.data_byte >= CH_UPPER_A) && (in_data.data_byte <= CH_UPPER_Z);

  always_comb begin
    q_word.cmd    = in_data.cmd;
    q_word.chr    = (nocase_r && is_upper) ? in_data.data_byte + CASE_DELTA
                                           : in_data.data_byte;
    q_word.last   = in_data.last_of_pattern;
    q_word.id     = in_data.pattern_id;
    q_word.offset = in_data.start_offset;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mpbm_fifo.sv =====
// two-entry queue between front and back
`default_nettype none
module mpbm_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mpbm_pkg::op_t push_word,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output mpbm_pkg::op_t      pop_word
);
  import mpbm_pkg::*;

  op_t        slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_word  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mpbm_back.sv =====
// back end: trie store, link build and automaton walk
`default_nettype none
module mpbm_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire mpbm_pkg::op_t q_word,
  output logic               q_pop,
  output logic               busy,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mpbm_pkg::out_word_t out_data
);
  import mpbm_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LK    = 4'd2;
  localparam logic [3:0] S_FAILW = 4'd3;
  localparam logic [3:0] S_PFIN  = 4'd4;
  localparam logic [3:0] S_PLINK = 4'd5;
  localparam logic [3:0] S_CH    = 4'd6;
  localparam logic [3:0] S_BNXT  = 4'd7;
  localparam logic [3:0] S_BU    = 4'd8;
  localparam logic [3:0] S_BU2   = 4'd9;
  localparam logic [3:0] S_BCH   = 4'd10;
  localparam logic [3:0] S_BV    = 4'd11;
  localparam logic [3:0] S_BLNK  = 4'd12;

  localparam logic [1:0] M_PAT   = 2'd0;
  localparam logic [1:0] M_BUILD = 2'd1;
  localparam logic [1:0] M_TEXT  = 2'd2;

  localparam int HT_DEPTH = 1 << HT_W;

  // memories
  ht_ent_t          ht_mem   [HT_DEPTH];
  logic [NODE_W-1:0] fail_mem [NODES];
  nout_t            nout_mem [NODES];
  lnk_t             ol_mem   [NODES];
  lnk_t             fc_mem   [NODES];
  lnk_t             sib_mem  [NODES];
  logic [7:0]       eb_mem   [NODES];
  logic [NODE_W-1:0] bfs_mem  [NODES];

  logic              ht_we;   logic [HT_W-1:0]   ht_wa, ht_ra;   ht_ent_t ht_wd, ht_rd;
  logic              fail_we; logic [NODE_W-1:0] fail_wa, fail_ra, fail_wd, fail_rd;
  logic              nout_we; logic [NODE_W-1:0] nout_wa;  nout_t nout_wd, nout_rd;
  logic              ol_we;   logic [NODE_W-1:0] ol_wa;    lnk_t ol_wd, ol_rd;
  logic              fc_we;   logic [NODE_W-1:0] fc_wa, fc_ra;    lnk_t fc_wd, fc_rd;
  logic              sib_we;  logic [NODE_W-1:0] sib_wa, sib_ra;  lnk_t sib_wd, sib_rd;
  logic              eb_we;   logic [NODE_W-1:0] eb_wa, eb_ra;    logic [7:0] eb_wd, eb_rd;
  logic              bfs_we;  logic [NODE_W-1:0] bfs_wa, bfs_ra, bfs_wd, bfs_rd;
  logic [NODE_W-1:0] nd_ra;

  always_ff @(posedge clk) begin
    if (ht_we) ht_mem[ht_wa] <= ht_wd;
    ht_rd <= ht_mem[ht_ra];
  end
  always_ff @(posedge clk) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_rd <= fail_mem[fail_ra];
  end
  always_ff @(posedge clk) begin
    if (nout_we) nout_mem[nout_wa] <= nout_wd;
    nout_rd <= nout_mem[nd_ra];
  end
  always_ff @(posedge clk) begin
    if (ol_we) ol_mem[ol_wa] <= ol_wd;
    ol_rd <= ol_mem[nd_ra];
  end
  always_ff @(posedge clk) begin
    if (fc_we) fc_mem[fc_wa] <= fc_wd;
    fc_rd <= fc_mem[fc_ra];
  end
  always_ff @(posedge clk) begin
    if (sib_we) sib_mem[sib_wa] <= sib_wd;
    sib_rd <= sib_mem[sib_ra];
  end
  always_ff @(posedge clk) begin
    if (eb_we) eb_mem[eb_wa] <= eb_wd;
    eb_rd <= eb_mem[eb_ra];
  end
  always_ff @(posedge clk) begin
    if (bfs_we) bfs_mem[bfs_wa] <= bfs_wd;
    bfs_rd <= bfs_mem[bfs_ra];
  end

  // control registers
  logic [3:0]        state_r, state_nxt;
  logic [HT_W-1:0]   clr_r, clr_nxt;
  logic [CNT_W-1:0]  ncnt_r, ncnt_nxt;
  logic [NODE_W-1:0] cursor_r, cursor_nxt;
  logic [6:0]        plen_r, plen_nxt;
  logic              built_r, built_nxt;
  logic [NODE_W-1:0] search_r, search_nxt;
  logic [OFF_W-1:0]  tpos_r, tpos_nxt;
  lnk_t              rhead_r, rhead_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [NODE_W-1:0] lk_r, lk_nxt;
  logic [7:0]        c_r, c_nxt;
  logic [HT_W-1:0]   probe_r, probe_nxt;
  logic              hit_r, hit_nxt;
  logic [NODE_W-1:0] w_r, w_nxt;
  logic              last_r, last_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              rootph_r, rootph_nxt;
  logic [NODE_W-1:0] f_r, f_nxt;
  lnk_t              ch_r, ch_nxt;
  lnk_t              nch_r, nch_nxt;
  logic [NODE_W-1:0] v_r, v_nxt;
  logic [NODE_W-1:0] t_r, t_nxt;
  logic [NODE_W-1:0] head_r, head_nxt;
  logic [NODE_W-1:0] tail_r, tail_nxt;
  logic              out_vld_r;
  out_word_t         out_r;

  logic              emit;
  out_word_t         eword;
  logic              out_free;
  logic              hit, miss;
  nout_t             o_cur;
  lnk_t              l_cur;
  logic [NODE_W-1:0] w_new;

  assign out_free  = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign busy      = (state_r == S_CLR);

  assign hit   = ht_rd.v && (ht_rd.key == {lk_r, c_r});
  assign miss  = !ht_rd.v;
  // root has no output and no output link
  assign o_cur = (t_r == '0) ? '0 : nout_rd;
  assign l_cur = (t_r == '0) ? '0 : ol_rd;
  assign w_new = ncnt_r[NODE_W-1:0];

  assign ht_ra   = probe_nxt;
  assign nd_ra   = t_nxt;
  assign fail_ra = (state_r == S_BU) ? bfs_rd : lk_r;
  assign fc_ra   = (state_r == S_BU) ? bfs_rd : lk_r;
  assign sib_ra  = ch_r.node;
  assign eb_ra   = ch_r.node;
  assign bfs_ra  = head_r;

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    ncnt_nxt   = ncnt_r;
    cursor_nxt = cursor_r;
    plen_nxt   = plen_r;
    built_nxt  = built_r;
    search_nxt = search_r;
    tpos_nxt   = tpos_r;
    rhead_nxt  = rhead_r;
    mode_nxt   = mode_r;
    lk_nxt     = lk_r;
    c_nxt      = c_r;
    probe_nxt  = probe_r;
    hit_nxt    = hit_r;
    w_nxt      = w_r;
    last_nxt   = last_r;
    id_nxt     = id_r;
    rootph_nxt = rootph_r;
    f_nxt      = f_r;
    ch_nxt     = ch_r;
    nch_nxt    = nch_r;
    v_nxt      = v_r;
    t_nxt      = t_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    eword      = '0;
    ht_we = 1'b0;   ht_wa = probe_r;  ht_wd = '0;
    fail_we = 1'b0; fail_wa = v_r;    fail_wd = t_r;
    nout_we = 1'b0; nout_wa = w_r;    nout_wd = '0;
    ol_we = 1'b0;   ol_wa = v_r;      ol_wd = '0;
    fc_we = 1'b0;   fc_wa = w_r;      fc_wd = '0;
    sib_we = 1'b0;  sib_wa = w_r;     sib_wd = '0;
    eb_we = 1'b0;   eb_wa = w_r;      eb_wd = c_r;
    bfs_we = 1'b0;  bfs_wa = tail_r;  bfs_wd = v_r;

    case (state_r)
      S_CLR: begin
        ht_we   = 1'b1;
        ht_wa   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {HT_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (q_valid) begin
          last_nxt = q_word.last;
          id_nxt   = q_word.id;
          c_nxt    = q_word.chr;
          case (q_word.cmd)
            CMD_PAT: begin
              if (built_r || plen_r >= MAX_DEPTH) begin
                if (out_free) begin
                  q_pop = 1'b1;
                  emit  = 1'b1;
                  eword.last_result = 1'b1;
                  if (built_r) begin
                    eword.status = ST_PHASE;
                  end else begin
                    eword.status = ST_CAP;
                    if (q_word.last) begin
                      cursor_nxt = '0;
                      plen_nxt   = '0;
                    end else begin
                      plen_nxt = DISCARD_LEN;
                    end
                  end
                end
              end else begin
                q_pop     = 1'b1;
                mode_nxt  = M_PAT;
                lk_nxt    = cursor_r;
                probe_nxt = edge_hash(cursor_r, q_word.chr);
                state_nxt = S_LK;
              end
            end
            CMD_BUILD: begin
              if (built_r) begin
                if (out_free) begin
                  q_pop = 1'b1;
                  emit  = 1'b1;
                  eword.status      = ST_DONE;
                  eword.last_result = 1'b1;
                end
              end else begin
                q_pop      = 1'b1;
                mode_nxt   = M_BUILD;
                rootph_nxt = 1'b1;
                ch_nxt     = rhead_r;
                head_nxt   = '0;
                tail_nxt   = '0;
                state_nxt  = S_BCH;
              end
            end
            CMD_TEXT: begin
              if (!built_r) begin
                if (out_free) begin
                  q_pop = 1'b1;
                  emit  = 1'b1;
                  eword.status      = ST_PHASE;
                  eword.last_result = 1'b1;
                end
              end else begin
                q_pop     = 1'b1;
                mode_nxt  = M_TEXT;
                lk_nxt    = search_r;
                probe_nxt = edge_hash(search_r, q_word.chr);
                state_nxt = S_LK;
              end
            end
            default: begin
              if (out_free) begin
                q_pop      = 1'b1;
                search_nxt = '0;
                tpos_nxt   = q_word.offset;
                emit       = 1'b1;
                eword.status      = ST_DONE;
                eword.last_result = 1'b1;
              end
            end
          endcase
        end
      end

      // one hash probe per cycle, next slot fetched ahead
      S_LK: begin
        if (mode_r == M_PAT) begin
          if (hit || miss) begin
            hit_nxt   = hit;
            w_nxt     = ht_rd.child;
            state_nxt = S_PFIN;
          end else begin
            probe_nxt = probe_r + 1'b1;
          end
        end else begin
          if (hit || (miss && lk_r == '0)) begin
            t_nxt = hit ? ht_rd.child : '0;
            if (mode_r == M_TEXT) begin
              search_nxt = t_nxt;
              state_nxt  = S_CH;
            end else begin
              state_nxt = S_BLNK;
            end
          end else if (miss) begin
            state_nxt = S_FAILW;
          end else begin
            probe_nxt = probe_r + 1'b1;
          end
        end
      end

      S_FAILW: begin
        lk_nxt    = fail_rd;
        probe_nxt = edge_hash(fail_rd, c_r);
        state_nxt = S_LK;
      end

      S_PFIN: begin
        if (out_free) begin
          emit = 1'b1;
          eword.last_result = 1'b1;
          if (!hit_r && ncnt_r == CNT_W'(NODES)) begin
            eword.status = ST_CAP;
            if (last_r) begin
              cursor_nxt = '0;
              plen_nxt   = '0;
            end else begin
              plen_nxt = DISCARD_LEN;
            end
            state_nxt = S_IDLE;
          end else begin
            eword.status = ST_DONE;
            if (!hit_r) begin
              w_nxt    = w_new;
              ncnt_nxt = ncnt_r + 1'b1;
              ht_we    = 1'b1;
              ht_wd    = '{v: 1'b1, key: {lk_r, c_r}, child: w_new};
              eb_we    = 1'b1;
              eb_wa    = w_new;
              fc_we    = 1'b1;
              fc_wa    = w_new;
              fc_wd    = '0;
              sib_we   = 1'b1;
              sib_wa   = w_new;
              sib_wd   = (lk_r == '0) ? rhead_r : fc_rd;
              nout_we  = 1'b1;
              nout_wa  = w_new;
              nout_wd  = last_r ? '{v: 1'b1, id: id_r} : '0;
              if (lk_r == '0) begin
                rhead_nxt = '{v: 1'b1, node: w_new};
                state_nxt = S_IDLE;
              end else begin
                state_nxt = S_PLINK;
              end
            end else begin
              nout_we   = last_r;
              nout_wa   = w_r;
              nout_wd   = '{v: 1'b1, id: id_r};
              state_nxt = S_IDLE;
            end
            cursor_nxt = hit_r ? w_r : w_new;
            plen_nxt   = plen_r + 7'd1;
            if (last_r) begin
              cursor_nxt = '0;
              plen_nxt   = '0;
            end
          end
        end
      end

      S_PLINK: begin
        fc_we     = 1'b1;
        fc_wa     = lk_r;
        fc_wd     = '{v: 1'b1, node: w_r};
        state_nxt = S_IDLE;
      end

      // walk the output chain, deepest node first
      S_CH: begin
        if (out_free) begin
          if (o_cur.v) begin
            emit = 1'b1;
            eword.status       = ST_MATCH;
            eword.match_id     = o_cur.id;
            eword.match_offset = tpos_r;
            eword.last_result  = !l_cur.v;
          end else if (!l_cur.v) begin
            emit = 1'b1;
            eword.status       = ST_DONE;
            eword.match_offset = tpos_r;
            eword.last_result  = 1'b1;
          end
          if (l_cur.v) begin
            t_nxt = l_cur.node;
          end else begin
            tpos_nxt  = tpos_r + 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      S_BNXT: begin
        if (head_r == tail_r) begin
          if (out_free) begin
            emit = 1'b1;
            eword.status      = ST_DONE;
            eword.last_result = 1'b1;
            cursor_nxt = '0;
            plen_nxt   = '0;
            built_nxt  = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_BU;
        end
      end

      S_BU: begin
        head_nxt  = head_r + 1'b1;
        state_nxt = S_BU2;
      end

      S_BU2: begin
        ch_nxt    = fc_rd;
        f_nxt     = fail_rd;
        state_nxt = S_BCH;
      end

      S_BCH: begin
        if (!ch_r.v) begin
          rootph_nxt = 1'b0;
          state_nxt  = S_BNXT;
        end else begin
          v_nxt     = ch_r.node;
          state_nxt = S_BV;
        end
      end

      S_BV: begin
        nch_nxt = sib_rd;
        c_nxt   = eb_rd;
        if (rootph_r) begin
          t_nxt     = '0;
          state_nxt = S_BLNK;
        end else begin
          lk_nxt    = f_r;
          probe_nxt = edge_hash(f_r, eb_rd);
          state_nxt = S_LK;
        end
      end

      S_BLNK: begin
        fail_we   = 1'b1;
        ol_we     = 1'b1;
        ol_wd     = o_cur.v ? '{v: 1'b1, node: t_r} : l_cur;
        bfs_we    = 1'b1;
        tail_nxt  = tail_r + 1'b1;
        ch_nxt    = nch_r;
        state_nxt = S_BCH;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      ncnt_r    <= CNT_W'(1);
      cursor_r  <= '0;
      plen_r    <= '0;
      built_r   <= 1'b0;
      search_r  <= '0;
      tpos_r    <= '0;
      rhead_r   <= '0;
      mode_r    <= M_PAT;
      rootph_r  <= 1'b0;
      head_r    <= '0;
      tail_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      ncnt_r    <= ncnt_nxt;
      cursor_r  <= cursor_nxt;
      plen_r    <= plen_nxt;
      built_r   <= built_nxt;
      search_r  <= search_nxt;
      tpos_r    <= tpos_nxt;
      rhead_r   <= rhead_nxt;
      mode_r    <= mode_nxt;
      rootph_r  <= rootph_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lk_r    <= lk_nxt;
    c_r     <= c_nxt;
    probe_r <= probe_nxt;
    hit_r   <= hit_nxt;
    w_r     <= w_nxt;
    last_r  <= last_nxt;
    id_r    <= id_nxt;
    f_r     <= f_nxt;
    ch_r    <= ch_nxt;
    nch_r   <= nch_nxt;
    v_r     <= v_nxt;
    t_r     <= t_nxt;
    if (emit) begin
      out_r <= eword;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/multi_pattern_byte_matcher.sv =====
// top level of the multi-pattern byte matcher
// Aho-Corasick matcher. After reset the edge hash table (8192 entries) is cleared
// one entry per cycle, and no word is taken until it is done; config writes are
// taken at any time. Each word is handled on its own by the back end. A pattern
// byte probes the edge hash table and may make a new node; a text byte follows
// fail links until an edge is found, then walks the output links in memory and
// reports each match. Build walks the trie breadth first and sets fail and output
// links for every node.
// A two-entry queue separates word intake from execution, and results leave
// through a one-word output register.
`default_nettype none
module multi_pattern_byte_matcher (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mpbm_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mpbm_pkg::out_word_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);
  import mpbm_pkg::*;

  logic busy;
  logic q_full, q_push, q_pop, q_valid;
  op_t  push_word, pop_word;

  mpbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_word    (push_word)
  );

  mpbm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_word  (pop_word)
  );

  mpbm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (pop_word),
    .q_pop     (q_pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench of the multi-pattern byte matcher: directed and random words vs a predictor
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mpbm_pkg::*;

  localparam int LIM = 40000;
  localparam int ND = 4096;
  localparam int MAXD = 64;
  localparam int MAXRES = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multi_pattern_byte_matcher i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [11:0] m_fail [ND];
  logic [16:0] m_nout [ND];
  logic [12:0] m_olink [ND];
  logic [19:0] m_edge [ND];
  int m_cnt, m_cursor, m_plen, m_search;
  bit m_built, m_fold;
  logic [47:0] m_pos;

  out_word_t match_q[$];
  int errors = 0;
  int snd_idle = 0, rcv_idle = 0;
  bit rcv_hold = 1'b0;
  int quiet = 0;

  function automatic logic [7:0] fold_byte(logic [7:0] c);
    if (m_fold && c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + CASE_DELTA;
    return c;
  endfunction

  function automatic int find_child(int u, logic [7:0] c);
    for (int v = 1; v < m_cnt; v++)
      if (m_edge[v] == {u[11:0], c}) return v;
    return -1;
  endfunction

  function automatic int goto_node(int s, logic [7:0] c);
    int nx;
    for (int g = 0; g <= ND; g++) begin
      nx = find_child(s, c);
      if (nx >= 0) return nx;
      if (s == 0) return 0;
      s = m_fail[s];
    end
    return 0;
  endfunction

  function automatic void set_links(int v, int vf);
    m_fail[v] = vf[11:0];
    m_olink[v] = m_nout[vf][16] ? {1'b1, vf[11:0]} : m_olink[vf];
  endfunction

  function automatic void build_trie();
    int bq[$];
    int u;
    for (int v = 1; v < m_cnt; v++)
      if (m_edge[v][19:8] == 0) begin
        set_links(v, 0);
        bq.push_back(v);
      end
    while (bq.size() > 0) begin
      u = bq.pop_front();
      for (int v = 1; v < m_cnt; v++)
        if (m_edge[v][19:8] == u) begin
          set_links(v, goto_node(m_fail[u], m_edge[v][7:0]));
          bq.push_back(v);
        end
    end
    m_cursor = 0;
    m_plen = 0;
    m_built = 1'b1;
  endfunction

  function automatic void push_res(logic [1:0] st, logic [15:0] id, logic [47:0] off);
    out_word_t r;
    r.status = st;
    r.match_id = id;
    r.match_offset = off;
    r.last_result = 1'b0;
    match_q.push_back(r);
  endfunction

  function automatic void predict(in_word_t w);
    int v, nd, n, t;
    logic [7:0] c;
    logic [12:0] lk;
    n = 1;
    case (w.cmd)
      CMD_PAT: begin
        if (m_built) push_res(ST_PHASE, 0, 0);
        else if (m_plen >= MAXD) begin
          push_res(ST_CAP, 0, 0);
          if (w.last_of_pattern) begin m_cursor = 0; m_plen = 0; end
          else m_plen = MAXD + 1;
        end else begin
          c = fold_byte(w.data_byte);
          v = find_child(m_cursor, c);
          if (v < 0 && m_cnt >= ND) begin
            push_res(ST_CAP, 0, 0);
            if (w.last_of_pattern) begin m_cursor = 0; m_plen = 0; end
            else m_plen = MAXD + 1;
          end else begin
            push_res(ST_DONE, 0, 0);
            if (v < 0) begin
              nd = m_cnt++;
              m_edge[nd] = {m_cursor[11:0], c};
              m_nout[nd] = '0;
              m_fail[nd] = '0;
              m_olink[nd] = '0;
            end else nd = v;
            m_cursor = nd;
            m_plen++;
            if (w.last_of_pattern) begin
              m_nout[nd] = {1'b1, w.pattern_id};
              m_cursor = 0;
              m_plen = 0;
            end
          end
        end
      end
      CMD_BUILD: begin
        push_res(ST_DONE, 0, 0);
        if (!m_built) build_trie();
      end
      CMD_TEXT: begin
        if (!m_built) push_res(ST_PHASE, 0, 0);
        else begin
          m_search = goto_node(m_search, fold_byte(w.data_byte));
          n = 0;
          lk = {1'b1, m_search[11:0]};
          while (lk[12] && n < MAXRES) begin
            t = int'(lk[11:0]);
            if (m_nout[t][16]) begin
              push_res(ST_MATCH, m_nout[t][15:0], m_pos);
              n++;
            end
            lk = m_olink[t];
          end
          if (n == 0) push_res(ST_DONE, 0, m_pos);
          m_pos++;
        end
      end
      default: begin
        push_res(ST_DONE, 0, 0);
        m_search = 0;
        m_pos = w.start_offset;
      end
    endcase
    match_q[$].last_result = 1'b1;
  endfunction

  function automatic void reset_model();
    m_cnt = 1; m_cursor = 0; m_plen = 0; m_built = 0; m_search = 0; m_pos = '0;
    for (int i = 0; i < ND; i++) begin
      m_fail[i] = '0; m_nout[i] = '0; m_olink[i] = '0; m_edge[i] = '0;
    end
  endfunction

  // sender: one word, with random gaps before it; valid stays up between words unless a gap is drawn
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk iff in_ready);
    predict(w);
  endtask

  task automatic send(logic [1:0] cmd, logic [7:0] b, bit lst = 0, logic [15:0] id = 0,
                      logic [47:0] off = 0);
    in_word_t w;
    w.cmd = cmd; w.data_byte = b; w.last_of_pattern = lst;
    w.pattern_id = id; w.start_offset = off;
    send_word(w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(CMD_TEXT, s[i]);
  endtask

  task automatic add_pattern(string s, logic [15:0] id);
    for (int i = 0; i < s.len(); i++)
      send(CMD_PAT, s[i], i == s.len() - 1, id, 48'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (match_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // fold is only changed with nothing in flight
  task automatic write_fold(bit f);
    drain();
    cfg_data <= f;
    cfg_valid <= 1'b1;
    @(posedge clk iff cfg_ready);
    m_fold = f;
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (match_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %p", out_data);
      end else begin
        if (out_data !== match_q[0]) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %p got %p", match_q[0], out_data);
        end
        void'(match_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rcv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // watchdog: cycles with nothing accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= LIM) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_phase_errors();
    send(CMD_TEXT, 8'h61);
    send(CMD_START, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
  endtask

  task automatic test_basic_match();
    write_fold(1'b0);
    add_pattern("he", 16'h0001);
    add_pattern("she", 16'hFFFF);
    add_pattern("his", 16'h0002);
    add_pattern("hers", 16'h0003);
    add_pattern("he", 16'h0004);
    send(CMD_PAT, 8'hFF, 0);
    send(CMD_PAT, 8'h00, 1, 16'h0005);
    send(CMD_BUILD, 0);
    send(CMD_BUILD, 0);
    send(CMD_PAT, 8'h61, 1, 16'h0009);
    send(CMD_START, 0, 0, 0, 48'hFFFF_FFFF_FFFE);
    send_text("ushers");
    send(CMD_TEXT, 8'hFF);
    send(CMD_TEXT, 8'h00);
    drain();
  endtask

  task automatic test_long_pattern();
    // over-long pattern is discarded, bytes past the limit report capacity
    for (int i = 0; i < MAXD + 3; i++) send(CMD_PAT, 8'h78, i == MAXD + 2, 16'h0077);
    add_pattern("xx", 16'h0010);
  endtask

  task automatic test_random(int nwords);
    string alpha;
    alpha = "hersiHERSabcx";
    if ($urandom_range(9) == 0) send(CMD_TEXT, 8'($urandom));
    send(CMD_BUILD, 0);
    send(CMD_START, 0, 0, 0, 48'({$urandom, $urandom}));
    for (int i = 0; i < nwords; i++) begin
      if ($urandom_range(19) == 0)
        send(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 16'($urandom),
             48'({$urandom, $urandom}));
      else send(CMD_TEXT, alpha[$urandom_range(0, alpha.len() - 1)]);
    end
  endtask

  task automatic test_backpressure();
    rcv_hold = 1'b1;
    fork
      begin repeat (300) @(posedge clk); rcv_hold = 1'b0; end
      for (int i = 0; i < 30; i++) send_text("h");
    join
  endtask

  initial begin
    reset_model();
    m_fold = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_phase_errors();
    test_long_pattern();
    write_fold(1'b1);
    add_pattern("ABc", 16'h0020);
    write_fold(1'b0);
    test_basic_match();
    send(CMD_START, 0, 0, 0, 48'h0);
    write_fold(1'b1);
    send_text("HERS");
    drain();
    snd_idle = 22; rcv_idle = 51;
    test_random(90);
    drain();
    write_fold(1'b0);
    snd_idle = 51; rcv_idle = 22;
    test_random(90);
    drain();
    write_fold(1'b1);
    snd_idle = 0; rcv_idle = 0;
    test_random(90);
    test_backpressure();
    drain();
    if (errors == 0 && match_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
